FILE: rtl/caf_pkg.sv
package caf_pkg;

  localparam int unsigned OpW   = 6;
  localparam int unsigned WordW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned FlagW = 4;
  localparam int unsigned BitW  = 3;

  // flag bit positions
  localparam int unsigned FlagZ = 3;
  localparam int unsigned FlagN = 2;
  localparam int unsigned FlagH = 1;
  localparam int unsigned FlagC = 0;

  // decimal adjust constants
  localparam logic [ByteW-1:0] DaaHiCorr  = 8'h60;
  localparam logic [ByteW-1:0] DaaLoCorr  = 8'h06;
  localparam logic [ByteW-1:0] DaaHiLimit = 8'h99;
  localparam logic [3:0]       DaaLoLimit = 4'h9;

  typedef enum logic [OpW-1:0] {
    OP_ADD   = 6'd0,
    OP_ADC   = 6'd1,
    OP_SUB   = 6'd2,
    OP_SBC   = 6'd3,
    OP_AND   = 6'd4,
    OP_XOR   = 6'd5,
    OP_OR    = 6'd6,
    OP_CP    = 6'd7,
    OP_INC8  = 6'd8,
    OP_DEC8  = 6'd9,
    OP_INC16 = 6'd10,
    OP_DEC16 = 6'd11,
    OP_ADD16 = 6'd12,
    OP_ADDSP = 6'd13,
    OP_DAA   = 6'd14,
    OP_CPL   = 6'd15,
    OP_CCF   = 6'd16,
    OP_SCF   = 6'd17,
    OP_RLCA  = 6'd18,
    OP_RRCA  = 6'd19,
    OP_RLA   = 6'd20,
    OP_RRA   = 6'd21,
    OP_RLC   = 6'd22,
    OP_RRC   = 6'd23,
    OP_RL    = 6'd24,
    OP_RR    = 6'd25,
    OP_SLA   = 6'd26,
    OP_SRA   = 6'd27,
    OP_SWAP  = 6'd28,
    OP_SRL   = 6'd29,
    OP_BIT   = 6'd30,
    OP_RES   = 6'd31,
    OP_SET   = 6'd32
  } op_e;

  typedef struct packed {
    logic [OpW-1:0]   action;
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
    logic [BitW-1:0]  bit_index;
    logic [FlagW-1:0] flags;
  } alu_in_t;

  typedef struct packed {
    logic [WordW-1:0] result;
    logic [FlagW-1:0] flags;
  } alu_out_t;

endpackage

FILE: rtl/caf_core.sv
module caf_core (
  input  caf_pkg::alu_in_t  item_i,
  output caf_pkg::alu_out_t res_o
);

  always_comb begin
    logic [7:0]  a, b, r8, corr, mask;
    logic [15:0] l16, r16, res;
    logic [3:0]  fi, f;
    logic        cin, t, use8, zupd;
    logic [8:0]  s9;
    logic [4:0]  s5;
    logic [16:0] s17;
    logic [12:0] s13;

    l16  = item_i.left;
    r16  = item_i.right;
    a    = l16[7:0];
    b    = r16[7:0];
    fi   = item_i.flags;
    cin  = fi[caf_pkg::FlagC];
    t    = 1'b0;
    r8   = a;
    res  = l16;
    f    = fi;
    use8 = 1'b0;
    zupd = 1'b0;
    corr = '0;
    mask = 8'(1) << item_i.bit_index;
    s9   = '0;
    s5   = '0;
    s17  = '0;
    s13  = '0;

    unique case (caf_pkg::op_e'(item_i.action)) inside
      caf_pkg::OP_ADD, caf_pkg::OP_ADC: begin
        t    = (item_i.action == caf_pkg::OP_ADC) ? cin : 1'b0;
        s9   = {1'b0, a} + {1'b0, b} + {8'd0, t};
        s5   = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, t};
        r8   = s9[7:0];
        use8 = 1'b1;
        zupd = 1'b1;
        f    = {1'b0, 1'b0, s5[4], s9[8]};
      end
      caf_pkg::OP_SUB, caf_pkg::OP_SBC, caf_pkg::OP_CP: begin
        t    = (item_i.action == caf_pkg::OP_SBC) ? cin : 1'b0;
        // bit above the msb is the borrow
        s9   = {1'b0, a} - {1'b0, b} - {8'd0, t};
        s5   = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, t};
        r8   = s9[7:0];
        use8 = (item_i.action != caf_pkg::OP_CP);
        f    = {(s9[7:0] == 8'd0), 1'b1, s5[4], s9[8]};
      end
      caf_pkg::OP_AND: begin
        r8 = a & b; use8 = 1'b1; zupd = 1'b1; f = 4'b0010;
      end
      caf_pkg::OP_XOR: begin
        r8 = a ^ b; use8 = 1'b1; zupd = 1'b1; f = 4'b0000;
      end
      caf_pkg::OP_OR: begin
        r8 = a | b; use8 = 1'b1; zupd = 1'b1; f = 4'b0000;
      end
      caf_pkg::OP_INC8: begin
        r8   = a + 8'd1;
        use8 = 1'b1;
        zupd = 1'b1;
        f    = {1'b0, 1'b0, (a[3:0] == 4'hF), cin};
      end
      caf_pkg::OP_DEC8: begin
        r8   = a - 8'd1;
        use8 = 1'b1;
        zupd = 1'b1;
        f    = {1'b0, 1'b1, (a[3:0] == 4'h0), cin};
      end
      caf_pkg::OP_INC16: res = l16 + 16'd1;
      caf_pkg::OP_DEC16: res = l16 - 16'd1;
      caf_pkg::OP_ADD16: begin
        s17 = {1'b0, l16} + {1'b0, r16};
        s13 = {1'b0, l16[11:0]} + {1'b0, r16[11:0]};
        res = s17[15:0];
        f   = {fi[caf_pkg::FlagZ], 1'b0, s13[12], s17[16]};
      end
      caf_pkg::OP_ADDSP: begin
        // flags from the unsigned low-byte add, sum from the signed offset
        s9  = {1'b0, a} + {1'b0, b};
        s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        res = l16 + {{8{b[7]}}, b};
        f   = {1'b0, 1'b0, s5[4], s9[8]};
      end
      caf_pkg::OP_DAA: begin
        f = fi & 4'b0101;
        if (cin || (!fi[caf_pkg::FlagN] && (a > caf_pkg::DaaHiLimit))) begin
          corr = corr | caf_pkg::DaaHiCorr;
          f[caf_pkg::FlagC] = 1'b1;
        end
        if (fi[caf_pkg::FlagH] || (!fi[caf_pkg::FlagN] && (a[3:0] > caf_pkg::DaaLoLimit))) begin
          corr = corr | caf_pkg::DaaLoCorr;
        end
        r8   = fi[caf_pkg::FlagN] ? (a - corr) : (a + corr);
        use8 = 1'b1;
        zupd = 1'b1;
      end
      caf_pkg::OP_CPL: begin
        r8 = ~a; use8 = 1'b1; f = {fi[caf_pkg::FlagZ], 1'b1, 1'b1, cin};
      end
      caf_pkg::OP_CCF: begin
        use8 = 1'b1; f = {fi[caf_pkg::FlagZ], 1'b0, 1'b0, ~cin};
      end
      caf_pkg::OP_SCF: begin
        use8 = 1'b1; f = {fi[caf_pkg::FlagZ], 1'b0, 1'b0, 1'b1};
      end
      caf_pkg::OP_RLCA, caf_pkg::OP_RLC: begin
        r8   = {a[6:0], a[7]};
        use8 = 1'b1;
        zupd = (item_i.action == caf_pkg::OP_RLC);
        f    = {3'b000, a[7]};
      end
      caf_pkg::OP_RRCA, caf_pkg::OP_RRC: begin
        r8   = {a[0], a[7:1]};
        use8 = 1'b1;
        zupd = (item_i.action == caf_pkg::OP_RRC);
        f    = {3'b000, a[0]};
      end
      caf_pkg::OP_RLA, caf_pkg::OP_RL: begin
        r8   = {a[6:0], cin};
        use8 = 1'b1;
        zupd = (item_i.action == caf_pkg::OP_RL);
        f    = {3'b000, a[7]};
      end
      caf_pkg::OP_RRA, caf_pkg::OP_RR: begin
        r8   = {cin, a[7:1]};
        use8 = 1'b1;
        zupd = (item_i.action == caf_pkg::OP_RR);
        f    = {3'b000, a[0]};
      end
      caf_pkg::OP_SLA: begin
        r8 = {a[6:0], 1'b0}; use8 = 1'b1; zupd = 1'b1; f = {3'b000, a[7]};
      end
      caf_pkg::OP_SRA: begin
        r8 = {a[7], a[7:1]}; use8 = 1'b1; zupd = 1'b1; f = {3'b000, a[0]};
      end
      caf_pkg::OP_SWAP: begin
        r8 = {a[3:0], a[7:4]}; use8 = 1'b1; zupd = 1'b1; f = 4'b0000;
      end
      caf_pkg::OP_SRL: begin
        r8 = {1'b0, a[7:1]}; use8 = 1'b1; zupd = 1'b1; f = {3'b000, a[0]};
      end
      caf_pkg::OP_BIT: begin
        f = {((a & mask) == 8'd0), 1'b0, 1'b1, cin};
      end
      caf_pkg::OP_RES: begin
        r8 = a & ~mask; use8 = 1'b1;
      end
      caf_pkg::OP_SET: begin
        r8 = a | mask; use8 = 1'b1;
      end
      default: ;  // unused codes pass left and flags through
    endcase

    if (use8) begin
      res = {8'd0, r8};
    end
    if (zupd) begin
      f[caf_pkg::FlagZ] = (r8 == 8'd0);
    end

    res_o.result = res;
    res_o.flags  = f;
  end

endmodule

FILE: rtl/cpu_alu_with_flags.sv
// an item taken with start_i is held in the operand register, then the result
// register; result_o/flags_out_o show it with done_o high for exactly one cycle
// throughput: one item per cycle, busy_o never rises; the receiver cannot stall
// the operand register feeds one pass of alu logic into the result register
// reset (async, active low) clears the item valid and done strobe only
module cpu_alu_with_flags (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [caf_pkg::OpW-1:0]       action_i,
  input  logic [caf_pkg::WordW-1:0]     left_i,
  input  logic [caf_pkg::WordW-1:0]     right_i,
  input  logic [caf_pkg::BitW-1:0]      bit_index_i,
  input  logic [caf_pkg::FlagW-1:0]     flags_in_i,
  output logic                          done_o,
  output logic [caf_pkg::WordW-1:0]     result_o,
  output logic [caf_pkg::FlagW-1:0]     flags_out_o
);

  logic              in_vld_q;
  caf_pkg::alu_in_t  in_q;
  caf_pkg::alu_out_t alu_d;
  caf_pkg::alu_out_t out_q;
  logic              done_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      in_vld_q <= start_i;
      done_q   <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      in_q.action    <= action_i;
      in_q.left      <= left_i;
      in_q.right     <= right_i;
      in_q.bit_index <= bit_index_i;
      in_q.flags     <= flags_in_i;
    end
    if (in_vld_q) begin
      out_q <= alu_d;
    end
  end

  caf_core u_core (
    .item_i (in_q),
    .res_o  (alu_d)
  );

  assign done_o      = done_q;
  assign result_o    = out_q.result;
  assign flags_out_o = out_q.flags;

endmodule

FILE: test/cpu_alu_flags_monitor.sv
`timescale 1ns / 1ps

module cpu_alu_flags_monitor
  import caf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  logic [OpW-1:0]   action_i,
  input  logic [WordW-1:0] left_i,
  input  logic [WordW-1:0] right_i,
  input  logic [BitW-1:0]  bit_index_i,
  input  logic [FlagW-1:0] flags_in_i,
  input  logic             done_i,
  input  logic [WordW-1:0] result_i,
  input  logic [FlagW-1:0] flags_out_i,
  output int               fail_count_o,
  output int               outstanding_o,
  output int               compared_o
);

  alu_out_t alu_results_q[$];
  int mismatches = 0;
  int compared   = 0;

  assign fail_count_o  = mismatches;
  assign compared_o    = compared;

  always @(posedge clk_i) outstanding_o <= alu_results_q.size();

  function automatic alu_out_t alu_eval(alu_in_t op);
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  r8;
    logic [7:0]  corr;
    logic [8:0]  sum9;
    logic [4:0]  nib;
    logic [16:0] w17;
    logic [12:0] w13;
    logic        cin;
    logic        sub_n;
    logic        t;
    logic        is_word;
    alu_out_t    r;
    a       = op.left[7:0];
    b       = op.right[7:0];
    cin     = op.flags[FlagC];
    sub_n   = op.flags[FlagN];
    r8      = 8'h00;
    is_word = 1'b0;
    r.result = op.left;
    r.flags  = op.flags;
    case (op.action)
      OP_ADD, OP_ADC: begin
        t    = (op.action == OP_ADC) ? cin : 1'b0;
        sum9 = {1'b0, a} + {1'b0, b} + {8'h00, t};
        nib  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, t};
        r8   = sum9[7:0];
        r.flags = {r8 == 8'h00, 1'b0, nib[4], sum9[8]};
      end
      OP_SUB, OP_SBC, OP_CP: begin
        t    = (op.action == OP_SBC) ? cin : 1'b0;
        sum9 = {1'b0, a} - {1'b0, b} - {8'h00, t};
        nib  = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, t};
        r8   = sum9[7:0];
        r.flags = {r8 == 8'h00, 1'b1, nib[4], sum9[8]};
        // compare keeps the whole left word
        is_word = (op.action == OP_CP);
      end
      OP_AND: begin
        r8 = a & b;
        r.flags = {r8 == 8'h00, 1'b0, 1'b1, 1'b0};
      end
      OP_XOR: begin
        r8 = a ^ b;
        r.flags = {r8 == 8'h00, 3'b000};
      end
      OP_OR: begin
        r8 = a | b;
        r.flags = {r8 == 8'h00, 3'b000};
      end
      OP_INC8: begin
        r8 = a + 8'h01;
        r.flags = {r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin};
      end
      OP_DEC8: begin
        r8 = a - 8'h01;
        r.flags = {r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin};
      end
      OP_INC16: begin
        is_word  = 1'b1;
        r.result = op.left + 16'h0001;
      end
      OP_DEC16: begin
        is_word  = 1'b1;
        r.result = op.left - 16'h0001;
      end
      OP_ADD16: begin
        is_word  = 1'b1;
        w17      = {1'b0, op.left} + {1'b0, op.right};
        w13      = {1'b0, op.left[11:0]} + {1'b0, op.right[11:0]};
        r.result = w17[15:0];
        r.flags  = {op.flags[FlagZ], 1'b0, w13[12], w17[16]};
      end
      OP_ADDSP: begin
        is_word  = 1'b1;
        r.result = op.left + {{8{b[7]}}, b};
        // carries come from the unsigned low-byte sum
        sum9     = {1'b0, a} + {1'b0, b};
        nib      = {1'b0, a[3:0]} + {1'b0, b[3:0]};
        r.flags  = {2'b00, nib[4], sum9[8]};
      end
      OP_DAA: begin
        corr    = 8'h00;
        r.flags = {1'b0, sub_n, 1'b0, cin};
        if (cin || (!sub_n && a > DaaHiLimit)) begin
          corr = corr | DaaHiCorr;
          r.flags[FlagC] = 1'b1;
        end
        if (op.flags[FlagH] || (!sub_n && a[3:0] > DaaLoLimit)) begin
          corr = corr | DaaLoCorr;
        end
        r8 = sub_n ? (a - corr) : (a + corr);
        r.flags[FlagZ] = (r8 == 8'h00);
      end
      OP_CPL: begin
        r8 = ~a;
        r.flags = {op.flags[FlagZ], 1'b1, 1'b1, cin};
      end
      OP_CCF: begin
        r8 = a;
        r.flags = {op.flags[FlagZ], 2'b00, ~cin};
      end
      OP_SCF: begin
        r8 = a;
        r.flags = {op.flags[FlagZ], 2'b00, 1'b1};
      end
      OP_RLCA, OP_RLC: begin
        r8 = {a[6:0], a[7]};
        r.flags = {(op.action == OP_RLC) && (r8 == 8'h00), 2'b00, a[7]};
      end
      OP_RRCA, OP_RRC: begin
        r8 = {a[0], a[7:1]};
        r.flags = {(op.action == OP_RRC) && (r8 == 8'h00), 2'b00, a[0]};
      end
      OP_RLA, OP_RL: begin
        r8 = {a[6:0], cin};
        r.flags = {(op.action == OP_RL) && (r8 == 8'h00), 2'b00, a[7]};
      end
      OP_RRA, OP_RR: begin
        r8 = {cin, a[7:1]};
        r.flags = {(op.action == OP_RR) && (r8 == 8'h00), 2'b00, a[0]};
      end
      OP_SLA: begin
        r8 = {a[6:0], 1'b0};
        r.flags = {r8 == 8'h00, 2'b00, a[7]};
      end
      OP_SRA: begin
        r8 = {a[7], a[7:1]};
        r.flags = {r8 == 8'h00, 2'b00, a[0]};
      end
      OP_SWAP: begin
        r8 = {a[3:0], a[7:4]};
        r.flags = {r8 == 8'h00, 3'b000};
      end
      OP_SRL: begin
        r8 = {1'b0, a[7:1]};
        r.flags = {r8 == 8'h00, 2'b00, a[0]};
      end
      OP_BIT: begin
        is_word = 1'b1;
        r.flags = {~a[op.bit_index], 1'b0, 1'b1, cin};
      end
      OP_RES: r8 = a & ~(8'h01 << op.bit_index);
      OP_SET: r8 = a | (8'h01 << op.bit_index);
      // unused codes pass left and flags straight through
      default: is_word = 1'b1;
    endcase
    if (!is_word) r.result = {8'h00, r8};
    return r;
  endfunction

  always @(posedge clk_i) begin : watch
    alu_out_t want;
    alu_in_t  op;
    if (rst_ni) begin
      if (done_i) begin
        if (alu_results_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("%0t: result %h flags %h with no item outstanding",
                     $time, result_i, flags_out_i);
          end
          mismatches++;
        end else begin
          want = alu_results_q.pop_front();
          compared++;
          if (result_i !== want.result || flags_out_i !== want.flags) begin
            if (mismatches < 10) begin
              $display("%0t: mismatch result exp %h got %h, flags exp %h got %h",
                       $time, want.result, result_i, want.flags, flags_out_i);
            end
            mismatches++;
          end
        end
      end
      if (start_i && !busy_i) begin
        op.action    = action_i;
        op.left      = left_i;
        op.right     = right_i;
        op.bit_index = bit_index_i;
        op.flags     = flags_in_i;
        alu_results_q.push_back(alu_eval(op));
      end
    end
  end

endmodule

FILE: test/tb_cpu_alu_with_flags.sv
`timescale 1ns / 1ps

module tb_cpu_alu_with_flags;
  import caf_pkg::*;

  localparam int RandomItems = 1850;
  localparam int CycleLimit  = 200000;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  logic [OpW-1:0]   action_i;
  logic [WordW-1:0] left_i;
  logic [WordW-1:0] right_i;
  logic [BitW-1:0]  bit_index_i;
  logic [FlagW-1:0] flags_in_i;
  logic             done_o;
  logic [WordW-1:0] result_o;
  logic [FlagW-1:0] flags_out_o;

  int fail_count;
  int outstanding;
  int compared;
  int items_sent  = 0;
  int idle_pct    = 0;
  int cycle_count = 0;

  always #4 clk_i = ~clk_i;

  cpu_alu_with_flags dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .action_i    (action_i),
    .left_i      (left_i),
    .right_i     (right_i),
    .bit_index_i (bit_index_i),
    .flags_in_i  (flags_in_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .flags_out_o (flags_out_o)
  );

  cpu_alu_flags_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .action_i      (action_i),
    .left_i        (left_i),
    .right_i       (right_i),
    .bit_index_i   (bit_index_i),
    .flags_in_i    (flags_in_i),
    .done_i        (done_o),
    .result_i      (result_o),
    .flags_out_i   (flags_out_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .compared_o    (compared)
  );

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // called and returns at a falling edge
  task automatic send_item(input logic [OpW-1:0] act, input logic [WordW-1:0] lft,
                           input logic [WordW-1:0] rgt, input logic [BitW-1:0] bidx,
                           input logic [FlagW-1:0] flg);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    action_i    <= act;
    left_i      <= lft;
    right_i     <= rgt;
    bit_index_i <= bidx;
    flags_in_i  <= flg;
    start_i     <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (outstanding != 0) @(negedge clk_i);
  endtask

  // operand values biased toward carry, sign and bcd boundaries
  function automatic logic [WordW-1:0] pick_word();
    logic [WordW-1:0] w;
    case ($urandom_range(6))
      0: w = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      1: w = {8'($urandom), 8'h0F + 8'($urandom_range(2))};
      2: w = {8'($urandom), 8'h7F + 8'($urandom_range(2))};
      3: w = {8'($urandom), 4'($urandom_range(9)), 4'($urandom_range(9))};
      4: w = {4'($urandom), 12'hFFF} + 16'($urandom_range(2));
      default: w = 16'($urandom);
    endcase
    return w;
  endfunction

  task automatic send_random();
    logic [OpW-1:0] act;
    if ($urandom_range(99) < 8) act = OpW'($urandom_range(63, int'(OP_SET) + 1));
    else act = OpW'($urandom_range(int'(OP_SET), 0));
    send_item(act, pick_word(), pick_word(), 3'($urandom), 4'($urandom));
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    action_i    = '0;
    left_i      = '0;
    right_i     = '0;
    bit_index_i = '0;
    flags_in_i  = '0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every operation once, alternating all-ones and all-zero operands
    for (int op = 0; op <= int'(OP_SET); op++) begin
      if (op % 2 == 0) send_item(OpW'(op), 16'hFFFF, 16'hFFFF, 3'd7, 4'hF);
      else send_item(OpW'(op), 16'h0000, 16'h0000, 3'd0, 4'h0);
    end
    // unused codes pass through
    send_item(OpW'(int'(OP_SET) + 1), 16'hA55A, 16'h1234, 3'd3, 4'h5);
    send_item(6'h3F, 16'h5AA5, 16'hFFFF, 3'd4, 4'hA);
    // compare equal low bytes with differing high bytes
    send_item(OP_CP, 16'hAB12, 16'h0012, 3'd0, 4'h0);
    // decimal adjust after add and after subtract with both borrows
    send_item(OP_DAA, 16'h009A, 16'h0000, 3'd0, 4'h0);
    send_item(OP_DAA, 16'h0000, 16'h0000, 3'd0, 4'h7);
    // stack offset with negative byte
    send_item(OP_ADDSP, 16'hFFF8, 16'h0080, 3'd0, 4'hF);
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 55 : 0;
      for (int i = 0; i < RandomItems / 3; i++) begin
        send_random();
        if (i % 200 == 199) drain_results();
      end
      drain_results();
    end

    repeat (6) @(negedge clk_i);
    $display("sent %0d items (all 33 operations and unused codes), %0d results compared",
             items_sent, compared);
    $display("sender idle rates 11, 55 and 0 percent, with drains between bursts");
    if (fail_count == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/caf_pkg.sv
rtl/caf_core.sv
rtl/cpu_alu_with_flags.sv
test/cpu_alu_flags_monitor.sv
test/tb_cpu_alu_with_flags.sv
